@@ hw/rtl/msa_pkg.sv @@
// ----------------------------------------------------------------------------
// Max-gap slot allocator package
// Shared constants, result and operation codes, and the occupancy-word
// priority encoder used by the gap unit.
// ----------------------------------------------------------------------------
package msa_pkg;

	// Default row capacity
	localparam int MAX_SEATS_DEF = 1024;

	// Occupancy map word geometry
	localparam int WORD_W  = 64;
	localparam int WORD_BW = 6;

	// Fixed field widths
	localparam int NUM_SEATS_W = 11;
	localparam int SLOT_W      = 10;
	localparam int STATUS_W    = 2;

	localparam logic [NUM_SEATS_W-1:0] NUM_SEATS_RESET = 11'd1024;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED     = 2'd0,
		ST_FULL          = 2'd1,
		ST_RELEASED      = 2'd2,
		ST_EMPTY_RELEASE = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Return the index of the lowest set bit (zero when none is set)
	function automatic logic [WORD_BW-1:0] lowest_one(input logic [WORD_W-1:0] v);
		logic [WORD_BW-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = WORD_BW'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ hw/rtl/msa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module msa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/msa_gap_unit.sv @@
// ----------------------------------------------------------------------------
// Max-gap slot allocator gap unit
// Takes one occupied slot per step from the current occupancy word and
// tracks the last occupied slot, the count and the widest gap, edge gap included.
// ----------------------------------------------------------------------------
module msa_gap_unit #(
	parameter int AW = 4,
	parameter int NW = 11,
	localparam int PW = AW + msa_pkg::WORD_BW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       init,
	input  logic                       step,
	input  logic [AW-1:0]              word_idx,
	input  logic [msa_pkg::WORD_W-1:0] mask,
	output logic [msa_pkg::WORD_W-1:0] mask_next,
	output logic                       seen,
	output logic [NW-1:0]              used,
	output logic [PW-1:0]              last,
	output logic [PW-1:0]              best_dist,
	output logic [PW-1:0]              best_pos
);

	import msa_pkg::*;

	logic [WORD_BW-1:0] bit_idx;
	logic [PW-1:0]      pos;
	logic [PW-1:0]      half_gap;
	logic               seen_q;
	logic [NW-1:0]      used_q;
	logic [PW-1:0]      last_q;
	logic [PW-1:0]      best_dist_q;
	logic [PW-1:0]      best_pos_q;

	// Locate the next occupied slot and half its distance to the previous one
	assign bit_idx   = lowest_one(mask);
	assign pos       = {word_idx, bit_idx};
	assign half_gap  = (pos - last_q) >> 1;
	assign mask_next = mask & (mask - WORD_W'(1));

	// Track gap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			used_q <= '0;
		end else if (init) begin
			seen_q <= 1'b0;
			used_q <= '0;
		end else if (step) begin
			seen_q <= 1'b1;
			used_q <= used_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			last_q <= pos;
			if (!seen_q) begin
				best_dist_q <= pos;
				best_pos_q  <= '0;
			end else if (half_gap > best_dist_q) begin
				best_dist_q <= half_gap;
				best_pos_q  <= last_q + half_gap;
			end
		end
	end

	assign seen      = seen_q;
	assign used      = used_q;
	assign last      = last_q;
	assign best_dist = best_dist_q;
	assign best_pos  = best_pos_q;

endmodule

@@ hw/rtl/max_gap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// Max-gap slot allocator
// Allocates the free slot farthest from any occupied slot, or releases one.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result. The occupancy map sits in a
// RAM of 64-slot words. An allocate reads the row one word at a time and
// feeds each occupied slot through a shared gap unit, one slot per cycle. Each
// word passes through fetch, load and end of scan; then the slot is chosen
// and marked in the decide, map read and map write states, unless the row is
// full. A release runs only the map read and map write states (none when the
// slot is out of range). The result then waits in an output register while
// the next item may be accepted. After reset a clearing pass writes every map
// word, one per cycle, before the first item is taken; num_seats writes are
// accepted at any time.
module max_gap_slot_allocator #(
	parameter int MAX_SEATS = msa_pkg::MAX_SEATS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [msa_pkg::SLOT_W-1:0]      release_slot,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [msa_pkg::SLOT_W-1:0]      slot_index,
	output logic [msa_pkg::STATUS_W-1:0]    status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [msa_pkg::NUM_SEATS_W-1:0] num_seats
);

	import msa_pkg::*;

	localparam int DEPTH = (MAX_SEATS + WORD_W - 1) / WORD_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = AW + WORD_BW;
	localparam int NW    = $clog2(MAX_SEATS + 1);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_FETCH  = 9'b000000100,
		S_LOAD   = 9'b000001000,
		S_SCAN   = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_UPD_RD = 9'b001000000,
		S_UPD_WR = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t                  state_q;
	logic [NUM_SEATS_W-1:0]  num_seats_q;
	logic [AW-1:0]           clr_addr_q;
	logic [AW-1:0]           word_q;
	logic [WORD_W-1:0]       mask_q;
	op_t                     op_q;
	logic [SLOT_W-1:0]       rs_q;
	logic [PW-1:0]           tgt_q;
	logic [PW-1:0]           res_slot_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic [SLOT_W-1:0]       slot_index_q;
	status_t                 status_q;

	logic                    in_accept;
	logic                    out_free;
	logic [NW-1:0]           row_len;
	logic [PW-1:0]           row_last;
	logic [AW-1:0]           last_word;
	logic [WORD_W-1:0]       row_mask;
	logic                    rs_in_range;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [WORD_W-1:0]       ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [WORD_W-1:0]       ram_rdata;
	logic [WORD_W-1:0]       tgt_bit;
	logic                    tgt_occupied;

	logic                    gap_init;
	logic                    gap_step;
	logic [WORD_W-1:0]       gap_mask_next;
	logic                    gap_seen;
	logic [NW-1:0]           gap_used;
	logic [PW-1:0]           gap_last;
	logic [PW-1:0]           gap_best_dist;
	logic [PW-1:0]           gap_best_pos;

	// Handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Hold the row length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_seats_q <= NUM_SEATS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_seats_q <= num_seats;
		end
	end

	// Clamp the row length to 1..MAX_SEATS
	always_comb begin
		if (num_seats_q == '0) begin
			row_len = NW'(1);
		end else if (int'(num_seats_q) > MAX_SEATS) begin
			row_len = NW'(MAX_SEATS);
		end else begin
			row_len = NW'(num_seats_q);
		end
	end

	assign row_last  = PW'(row_len - NW'(1));
	assign last_word = row_last[PW-1:WORD_BW];
	assign row_mask  = (word_q == last_word)
		? ({WORD_W{1'b1}} >> (WORD_BW'(WORD_W - 1) - row_last[WORD_BW-1:0]))
		: {WORD_W{1'b1}};

	assign rs_in_range = (int'(release_slot) < MAX_SEATS);

	// Occupancy map port control
	assign tgt_bit      = WORD_W'(1) << tgt_q[WORD_BW-1:0];
	assign tgt_occupied = |(ram_rdata & tgt_bit);
	assign ram_raddr    = (state_q == S_UPD_RD) ? tgt_q[PW-1:WORD_BW] : word_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tgt_q[PW-1:WORD_BW];
		ram_wdata = ram_rdata | tgt_bit;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (state_q == S_UPD_WR) begin
			if (op_q == OP_ALLOC) begin
				ram_we = 1'b1;
			end else begin
				ram_we    = tgt_occupied;
				ram_wdata = ram_rdata & ~tgt_bit;
			end
		end
	end

	msa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Gap unit drive
	assign gap_init = in_accept && (op_t'(op) == OP_ALLOC);
	assign gap_step = (state_q == S_SCAN) && (mask_q != '0);

	msa_gap_unit #(
		.AW(AW),
		.NW(NW)
	) u_gap (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (gap_init),
		.step     (gap_step),
		.word_idx (word_q),
		.mask     (mask_q),
		.mask_next(gap_mask_next),
		.seen     (gap_seen),
		.used     (gap_used),
		.last     (gap_last),
		.best_dist(gap_best_dist),
		.best_pos (gap_best_pos)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (op_t'(op) == OP_ALLOC) begin
							state_q <= S_FETCH;
						end else if (rs_in_range) begin
							state_q <= S_UPD_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_FETCH:  state_q <= S_LOAD;
				S_LOAD:   state_q <= S_SCAN;
				S_SCAN: begin
					if (mask_q == '0) begin
						state_q <= (word_q == last_word) ? S_DECIDE : S_FETCH;
					end
				end
				S_DECIDE: begin
					state_q <= (gap_used == row_len) ? S_DONE : S_UPD_RD;
				end
				S_UPD_RD: state_q <= S_UPD_WR;
				S_UPD_WR: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(op);
				rs_q   <= release_slot;
				word_q <= '0;
				tgt_q  <= PW'(release_slot);
				res_status_q <= ST_EMPTY_RELEASE;
			end
			S_LOAD: begin
				mask_q <= ram_rdata & row_mask;
			end
			S_SCAN: begin
				if (mask_q != '0) begin
					mask_q <= gap_mask_next;
				end else begin
					word_q <= word_q + AW'(1);
				end
			end
			S_DECIDE: begin
				res_slot_q   <= '0;
				res_status_q <= ST_FULL;
				if (!gap_seen) begin
					tgt_q <= '0;
				end else if ((row_last - gap_last) > gap_best_dist) begin
					tgt_q <= row_last;
				end else begin
					tgt_q <= gap_best_pos;
				end
			end
			S_UPD_WR: begin
				res_slot_q <= tgt_q;
				if (op_q == OP_ALLOC) begin
					res_status_q <= ST_ALLOCATED;
				end else begin
					res_status_q <= tgt_occupied ? ST_RELEASED : ST_EMPTY_RELEASE;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load on finish, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			slot_index_q <= (op_q == OP_RELEASE) ? rs_q : SLOT_W'(res_slot_q);
			status_q     <= res_status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_index = slot_index_q;
	assign status     = status_q;

endmodule

@@ hw/rtl/msa_checker.sv @@
// ----------------------------------------------------------------------------
// Max-gap slot allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module msa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [msa_pkg::SLOT_W-1:0]   slot_index,
	input logic [msa_pkg::STATUS_W-1:0] status
);

	import msa_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_index) && $stable(status))
		else $error("result changed while stalled");

	// A full row reports slot zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (slot_index == '0))
		else $error("row full result carries a nonzero slot");

	// Stall the input once an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

endmodule

bind max_gap_slot_allocator msa_checker u_msa_checker (.*);
